[design/assert_macros.svh]
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/sikc_pkg.sv]
package sikc_pkg;

	localparam int INDEX_BITS = 10;
	localparam int ORDER_BITS = 6;
	localparam int KEY_BITS   = ORDER_BITS + 4 * INDEX_BITS + 1;
	localparam int DIV_STEP   = 4;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	localparam logic REG_STATE_COUNT = 1'b0;
	localparam logic REG_SYM_MODE    = 1'b1;

	typedef logic [INDEX_BITS-1:0] idx_t;
	typedef idx_t [3:0] idx4_t;

	typedef struct packed {
		logic                  operation;
		logic [ORDER_BITS-1:0] order_k;
		idx_t                  index_a;
		idx_t                  index_b;
		idx_t                  index_c;
		idx_t                  index_d;
		logic [KEY_BITS-1:0]   packed_key;
	} req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key_out;
		logic [ORDER_BITS-1:0] k_out;
		idx_t                  out_a;
		idx_t                  out_b;
		idx_t                  out_c;
		idx_t                  out_d;
		logic                  bad_input;
	} rsp_t;

	typedef struct packed {
		op_t                   op;
		logic [KEY_BITS-1:0]   key;
		logic [ORDER_BITS-1:0] k;
		idx4_t                 idx;
		logic                  bad;
	} side_t;

	function automatic idx4_t order_sym(input idx4_t vi);
		idx4_t v;
		idx_t  t;
		v = vi;
		if (v[2] < v[0]) begin
			t = v[0]; v[0] = v[2]; v[2] = t;
		end
		if (v[3] < v[1]) begin
			t = v[1]; v[1] = v[3]; v[3] = t;
		end
		if (v[1] < v[0]) begin
			t = v[0]; v[0] = v[1]; v[1] = t;
			t = v[2]; v[2] = v[3]; v[3] = t;
		end
		if (v[0] == v[1] && v[3] < v[2]) begin
			t = v[2]; v[2] = v[3]; v[3] = t;
		end
		return v;
	endfunction

	function automatic idx4_t order_gen(input idx4_t vi);
		idx4_t v;
		idx_t  t;
		idx_t  m02;
		idx_t  m13;
		v = vi;
		m02 = (v[0] < v[2]) ? v[0] : v[2];
		m13 = (v[1] < v[3]) ? v[1] : v[3];
		if (m02 > m13) begin
			t = v[0]; v[0] = v[1]; v[1] = t;
			t = v[2]; v[2] = v[3]; v[3] = t;
		end
		if (v[0] > v[2]) begin
			t = v[0]; v[0] = v[2]; v[2] = t;
			t = v[1]; v[1] = v[3]; v[3] = t;
		end
		if (v[0] == v[1] && v[3] < v[2]) begin
			t = v[2]; v[2] = v[3]; v[3] = t;
		end
		if (v[0] == v[2] && v[3] < v[1]) begin
			t = v[1]; v[1] = v[3]; v[3] = t;
		end
		if (v[0] == v[3] && v[2] < v[1]) begin
			t = v[1]; v[1] = v[2]; v[2] = t;
		end
		return v;
	endfunction

endpackage

[design/sikc_div.sv]
module sikc_div #(
	parameter int W   = sikc_pkg::KEY_BITS,
	parameter int NW  = sikc_pkg::INDEX_BITS,
	parameter int SW  = $bits(sikc_pkg::side_t),
	parameter int BPS = sikc_pkg::DIV_STEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] divisor,
	input  logic          in_vld,
	input  logic [W-1:0]  in_dvd,
	input  logic [SW-1:0] in_side,
	output logic          out_vld,
	output logic [W-1:0]  out_quo,
	output logic [NW-1:0] out_rem,
	output logic [SW-1:0] out_side
);
	import sikc_pkg::*;

	localparam int S  = (W + BPS - 1) / BPS;
	localparam int PW = S * BPS;

	logic          vld_s [S];
	logic [PW-1:0] x_s   [S];
	logic [NW-1:0] r_s   [S];
	logic [SW-1:0] sd_s  [S];

	function automatic logic [PW+NW-1:0] steps(input logic [PW-1:0] xi,
		input logic [NW-1:0] ri, input logic [NW-1:0] d);
		logic [PW-1:0] x;
		logic [NW:0]   r;
		x = xi;
		r = {1'b0, ri};
		for (int i = 0; i < BPS; i++) begin
			r = {r[NW-1:0], x[PW-1]};
			x = {x[PW-2:0], 1'b0};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				x[0] = 1'b1;
			end
		end
		return {x, r[NW-1:0]};
	endfunction

	for (genvar j = 0; j < S; j++) begin : g_stage
		logic          v_in;
		logic [PW-1:0] x_in;
		logic [NW-1:0] r_in;
		logic [SW-1:0] sd_in;
		logic [PW+NW-1:0] nxt;
		if (j == 0) begin : g_first
			assign v_in  = in_vld;
			assign x_in  = PW'(in_dvd);
			assign r_in  = '0;
			assign sd_in = in_side;
		end else begin : g_rest
			assign v_in  = vld_s[j-1];
			assign x_in  = x_s[j-1];
			assign r_in  = r_s[j-1];
			assign sd_in = sd_s[j-1];
		end
		assign nxt = steps(x_in, r_in, divisor);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= v_in;
			end
		end
		always_ff @(posedge clk) begin
			x_s[j]  <= nxt[PW+NW-1:NW];
			r_s[j]  <= nxt[NW-1:0];
			sd_s[j] <= sd_in;
		end
	end

	assign out_vld  = vld_s[S-1];
	assign out_quo  = x_s[S-1][W-1:0];
	assign out_rem  = r_s[S-1];
	assign out_side = sd_s[S-1];

endmodule

[design/symmetric_index_key_codec_top.sv]
// channel   | handshake          | payload
// request   | start / busy       | req (req_t)
// result    | done strobe        | rsp (rsp_t)
// registers | psel/penable/pready| paddr, pwdata, prdata
// every request passes capture, canonical order, mixed-radix packing, then the
// four chained divide-by-state-count pipelines used for decode and the output register
// one request per cycle, busy stays low, reset clears only valid bits and registers
// results are strobed on done for one cycle, the receiver cannot stall
`include "assert_macros.svh"
module symmetric_index_key_codec_top #(
	parameter int DIV_BITS_PER_STAGE = sikc_pkg::DIV_STEP
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  sikc_pkg::req_t                 req,
	output logic                           done,
	output sikc_pkg::rsp_t                 rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sikc_pkg::ADDR_BITS-1:0] paddr,
	input  logic [sikc_pkg::DATA_BITS-1:0] pwdata,
	output logic [sikc_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);
	import sikc_pkg::*;

	logic [INDEX_BITS-1:0] state_count_q;
	logic                  sym_mode_q;
	logic [INDEX_BITS-1:0] n_eff;
	logic                  cfg_wr;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign n_eff  = (state_count_q == '0) ? INDEX_BITS'(1) : state_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_count_q <= INDEX_BITS'(1);
			sym_mode_q    <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_STATE_COUNT: state_count_q <= pwdata[INDEX_BITS-1:0];
				REG_SYM_MODE:    sym_mode_q    <= pwdata[0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_STATE_COUNT: prdata = DATA_BITS'(state_count_q);
			REG_SYM_MODE:    prdata = DATA_BITS'(sym_mode_q);
			default:         prdata = '0;
		endcase
	end

	// stage 1: capture request
	logic vld_s1;
	req_t req_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start & ~busy;
		end
	end
	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// stage 2: canonical order and range check
	idx4_t raw_idx;
	logic  vld_s2;
	side_t sd_s2;
	logic [KEY_BITS-1:0] dvd_s2;
	assign raw_idx = {req_s1.index_d, req_s1.index_c, req_s1.index_b, req_s1.index_a};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		sd_s2.op  <= op_t'(req_s1.operation);
		sd_s2.key <= '0;
		sd_s2.k   <= req_s1.order_k;
		sd_s2.idx <= sym_mode_q ? order_sym(raw_idx) : order_gen(raw_idx);
		sd_s2.bad <= (req_s1.index_a >= n_eff) | (req_s1.index_b >= n_eff) |
			(req_s1.index_c >= n_eff) | (req_s1.index_d >= n_eff);
		dvd_s2    <= req_s1.packed_key;
	end

	// stages 3 to 6: mixed-radix packing, one multiply-add per stage
	logic                vld_sm [5];
	side_t               sd_sm  [5];
	logic [KEY_BITS-1:0] acc_sm [5];
	logic [KEY_BITS-1:0] dvd_sm [5];
	assign vld_sm[0] = vld_s2;
	assign sd_sm[0]  = sd_s2;
	assign acc_sm[0] = KEY_BITS'(sd_s2.k);
	assign dvd_sm[0] = dvd_s2;
	for (genvar m = 0; m < 4; m++) begin : g_mac
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sm[m+1] <= 1'b0;
			end else begin
				vld_sm[m+1] <= vld_sm[m];
			end
		end
		always_ff @(posedge clk) begin
			acc_sm[m+1] <= KEY_BITS'(acc_sm[m] * n_eff) + KEY_BITS'(sd_sm[m].idx[m]);
			sd_sm[m+1]  <= sd_sm[m];
			dvd_sm[m+1] <= dvd_sm[m];
		end
	end

	// decode: four divisions by the state count, low digit first
	logic                  vld_d [5];
	side_t                 sd_d  [5];
	logic [KEY_BITS-1:0]   dvd_d [5];
	always_comb begin
		vld_d[0]    = vld_sm[4];
		dvd_d[0]    = dvd_sm[4];
		sd_d[0]     = sd_sm[4];
		sd_d[0].key = sd_sm[4].bad ? '0 : acc_sm[4];
	end
	for (genvar q = 0; q < 4; q++) begin : g_div
		logic                  o_vld;
		logic [KEY_BITS-1:0]   o_quo;
		logic [INDEX_BITS-1:0] o_rem;
		logic [$bits(side_t)-1:0] o_side;
		side_t                 o_sd;
		sikc_div #(
			.W   (KEY_BITS),
			.NW  (INDEX_BITS),
			.SW  ($bits(side_t)),
			.BPS (DIV_BITS_PER_STAGE)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (n_eff),
			.in_vld   (vld_d[q]),
			.in_dvd   (dvd_d[q]),
			.in_side  (sd_d[q]),
			.out_vld  (o_vld),
			.out_quo  (o_quo),
			.out_rem  (o_rem),
			.out_side (o_side)
		);
		assign o_sd = side_t'(o_side);
		always_comb begin
			vld_d[q+1] = o_vld;
			dvd_d[q+1] = o_quo;
			sd_d[q+1]  = o_sd;
			if (o_sd.op == OP_DECODE) begin
				sd_d[q+1].idx[3-q] = o_rem;
			end
		end
	end

	// output register
	logic done_q;
	rsp_t rsp_q;
	op_t  op_q;
	side_t fin;
	assign fin = sd_d[4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_d[4];
		end
	end
	always_ff @(posedge clk) begin
		op_q          <= fin.op;
		rsp_q.out_a   <= fin.idx[0];
		rsp_q.out_b   <= fin.idx[1];
		rsp_q.out_c   <= fin.idx[2];
		rsp_q.out_d   <= fin.idx[3];
		if (fin.op == OP_DECODE) begin
			rsp_q.key_out   <= '0;
			rsp_q.k_out     <= dvd_d[4][ORDER_BITS-1:0];
			rsp_q.bad_input <= |dvd_d[4][KEY_BITS-1:ORDER_BITS];
		end else begin
			rsp_q.key_out   <= fin.key;
			rsp_q.k_out     <= fin.k;
			rsp_q.bad_input <= fin.bad;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`ASSERT_IMPLY(a_enc_bad_zero, clk, arst_n, done_q && op_q == OP_ENCODE && rsp_q.bad_input,
		rsp_q.key_out == '0, "bad encode request with nonzero key")
	`ASSERT_IMPLY(a_dec_key_zero, clk, arst_n, done_q && op_q == OP_DECODE,
		rsp_q.key_out == '0, "decode result with nonzero key")
	`ASSERT_IMPLY(a_dec_digits, clk, arst_n, done_q && op_q == OP_DECODE,
		rsp_q.out_a < n_eff && rsp_q.out_d < n_eff, "decoded digit not below state count")
	`ASSERT_NEXT(a_cfg_count, clk, arst_n,
		cfg_wr && paddr[2] == REG_STATE_COUNT && pwdata[INDEX_BITS-1:0] != '0,
		n_eff == $past(pwdata[INDEX_BITS-1:0]), "state count write not taken")

endmodule
